>>> rtl/sega_pkg.sv
// Package for the sorted edge group aggregator: mode codes, the result record type,
// queue sizing and the aggregate selection function.
// No dependencies.
package sega_pkg;

  localparam logic [2:0] MODE_COUNT  = 3'd0;
  localparam logic [2:0] MODE_SUM    = 3'd1;
  localparam logic [2:0] MODE_MIN    = 3'd2;
  localparam logic [2:0] MODE_MAX    = 3'd3;
  localparam logic [2:0] MODE_SINGLE = 3'd4;

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [63:0]        pick_edge;
    logic [30:0]        group_count;
    logic signed [63:0] aggregate;
    logic               status;
    logic               last_of_batch;
  } res_t;

  function automatic logic signed [63:0] select_aggregate(
    input logic [2:0]         mode,
    input logic [30:0]        size,
    input logic signed [63:0] total,
    input logic signed [63:0] low,
    input logic signed [63:0] high
  );
    logic signed [63:0] v;
    case (mode)
      MODE_COUNT: v = {1'b0, size, 32'd0};
      MODE_SUM:   v = total;
      MODE_MIN:   v = low;
      MODE_MAX:   v = high;
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sorted_edge_group_aggregator_unit.sv
// Top level of the sorted edge group aggregator: group state, reduce logic and result queue.
// Depends on sega_pkg.
//
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | source_node target_node edge_kind edge_ident
//         |           |                       | weight batch_end
// output  | out       | out_valid / out_stall | pick_edge group_count aggregate status
//         |           |                       | last_of_batch
// config  | in        | cfg_valid / cfg_ready | mode
//
// Each accepted record is reduced into the group registers in the cycle of its transfer,
// and its zero, one or two results enter a four-entry queue at the same clock edge.
// A result can leave the next cycle. Records are accepted every cycle while the queue
// holds at most two results; records that give two results each are limited by the
// single output port.
// Reset is synchronous: it empties the queue, closes any group and sets mode to SINGLE.
// in_stall depends only on the queue fill level, never on in_valid.
module sorted_edge_group_aggregator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        source_node,
  input  logic [63:0]        target_node,
  input  logic [63:0]        edge_kind,
  input  logic [63:0]        edge_ident,
  input  logic signed [63:0] weight,
  input  logic               batch_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        pick_edge,
  output logic [30:0]        group_count,
  output logic signed [63:0] aggregate,
  output logic               status,
  output logic               last_of_batch,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         mode
);

  logic [2:0]         mode_reg;
  logic [63:0]        group_source, group_target, group_kind, group_pick;
  logic [30:0]        group_size;
  logic signed [63:0] group_total, group_low, group_high;
  logic               group_open, dropping;

  logic [63:0]        group_source_next, group_target_next, group_kind_next, group_pick_next;
  logic [30:0]        group_size_next;
  logic signed [63:0] group_total_next, group_low_next, group_high_next;
  logic               group_open_next, dropping_next;

  sega_pkg::res_t queue [sega_pkg::QUEUE_DEPTH];
  logic [sega_pkg::PTR_W-1:0] head, tail;
  logic [sega_pkg::CNT_W-1:0] count;

  logic               in_fire, out_fire, key_match, single_mode;
  logic [30:0]        size_inc;
  logic signed [63:0] sum_raw, sum_sat;
  logic               sum_ovf;
  logic               slot_a_valid, slot_b_valid;
  sega_pkg::res_t     slot_a, slot_b;
  logic [1:0]         push_n;
  sega_pkg::res_t     head_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = count > sega_pkg::CNT_W'(2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_fire  = out_valid && !out_stall;

  assign head_res      = queue[head];
  assign pick_edge     = head_res.pick_edge;
  assign group_count   = head_res.group_count;
  assign aggregate     = head_res.aggregate;
  assign status        = head_res.status;
  assign last_of_batch = head_res.last_of_batch;

  assign key_match   = group_open && source_node == group_source &&
                       target_node == group_target && edge_kind == group_kind;
  assign single_mode = mode_reg >= sega_pkg::MODE_SINGLE;
  assign size_inc    = (group_size < sega_pkg::COUNT_MAX) ? group_size + 31'd1 : group_size;
  assign sum_raw     = group_total + weight;
  assign sum_ovf     = (group_total[63] == weight[63]) && (sum_raw[63] != group_total[63]);
  assign sum_sat     = sum_ovf ? (group_total[63] ? sega_pkg::Q_MIN : sega_pkg::Q_MAX)
                               : sum_raw;

  always_comb begin
    group_source_next = group_source;
    group_target_next = group_target;
    group_kind_next   = group_kind;
    group_pick_next   = group_pick;
    group_size_next   = group_size;
    group_total_next  = group_total;
    group_low_next    = group_low;
    group_high_next   = group_high;
    group_open_next   = group_open;
    dropping_next     = dropping;
    slot_a_valid      = 1'b0;
    slot_b_valid      = 1'b0;
    slot_a            = '{pick_edge: group_pick, group_count: group_size,
                          aggregate: sega_pkg::select_aggregate(mode_reg, group_size,
                                                                group_total, group_low,
                                                                group_high),
                          status: 1'b0, last_of_batch: 1'b0};
    if (dropping) begin
      if (batch_end) begin
        dropping_next   = 1'b0;
        group_open_next = 1'b0;
      end
    end else if (key_match) begin
      group_size_next = size_inc;
      if (single_mode) begin
        slot_a_valid    = 1'b1;
        slot_a          = '{pick_edge: group_pick, group_count: size_inc, aggregate: '0,
                            status: 1'b1, last_of_batch: batch_end};
        group_open_next = 1'b0;
        dropping_next   = !batch_end;
      end else begin
        group_total_next = sum_sat;
        if (weight < group_low) begin
          group_low_next = weight;
          if (mode_reg == sega_pkg::MODE_MIN) begin
            group_pick_next = edge_ident;
          end
        end
        if (group_high < weight) begin
          group_high_next = weight;
          if (mode_reg == sega_pkg::MODE_MAX) begin
            group_pick_next = edge_ident;
          end
        end
        slot_b_valid = batch_end;
      end
    end else begin
      slot_a_valid      = group_open;
      group_source_next = source_node;
      group_target_next = target_node;
      group_kind_next   = edge_kind;
      group_size_next   = 31'd1;
      group_pick_next   = edge_ident;
      group_total_next  = weight;
      group_low_next    = weight;
      group_high_next   = weight;
      group_open_next   = 1'b1;
      slot_b_valid      = batch_end;
    end
    if (slot_b_valid) begin
      group_open_next = 1'b0;
    end
    slot_b = '{pick_edge: group_pick_next, group_count: group_size_next,
               aggregate: sega_pkg::select_aggregate(mode_reg, group_size_next,
                                                     group_total_next, group_low_next,
                                                     group_high_next),
               status: 1'b0, last_of_batch: 1'b1};
    push_n = in_fire ? {1'b0, slot_a_valid} + {1'b0, slot_b_valid} : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= sega_pkg::MODE_SINGLE;
      group_open <= 1'b0;
      dropping   <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_reg <= mode;
      end
      if (in_fire) begin
        group_open <= group_open_next;
        dropping   <= dropping_next;
      end
      tail  <= tail + sega_pkg::PTR_W'(push_n);
      head  <= head + sega_pkg::PTR_W'(out_fire);
      count <= count + sega_pkg::CNT_W'(push_n) - sega_pkg::CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      group_source <= group_source_next;
      group_target <= group_target_next;
      group_kind   <= group_kind_next;
      group_pick   <= group_pick_next;
      group_size   <= group_size_next;
      group_total  <= group_total_next;
      group_low    <= group_low_next;
      group_high   <= group_high_next;
      if (slot_a_valid) begin
        queue[tail] <= slot_a;
        if (slot_b_valid) begin
          queue[tail + sega_pkg::PTR_W'(1)] <= slot_b;
        end
      end else if (slot_b_valid) begin
        queue[tail] <= slot_b;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    count <= sega_pkg::CNT_W'(sega_pkg::QUEUE_DEPTH))
    else $error("Result queue holds more entries than its depth.");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && dropping) |-> push_n == 2'd0)
    else $error("A dropped record produced a result.");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && batch_end) |=> !group_open && !dropping)
    else $error("A group or drop state survived the end of a batch.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> group_count != 31'd0)
    else $error("A result left with an empty group count.");
`endif

endmodule

>>> verif/sorted_edge_group_aggregator_unit_test.sv
// Testbench for sorted_edge_group_aggregator_unit: drives sorted edge batches under every
// mode and checks each group result against an in-house reduce-by-key predictor.
// Depends on sega_pkg and the sorted_edge_group_aggregator_unit RTL.
`timescale 1ns / 100ps

module sorted_edge_group_aggregator_unit_test;

  localparam int QUIET_LIMIT = 500;
  localparam int RANDOM_RECORDS = 670;

  typedef struct packed {
    logic [63:0]        src;
    logic [63:0]        tgt;
    logic [63:0]        kind;
    logic [63:0]        ident;
    logic signed [63:0] weight;
    logic               be;
  } edge_rec_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [63:0]        pick_edge;
  logic [30:0]        group_count;
  logic signed [63:0] aggregate;
  logic               status;
  logic               last_of_batch;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         mode = sega_pkg::MODE_SINGLE;
  edge_rec_t          cur_rec = '0;

  edge_rec_t      record_queue[$];
  sega_pkg::res_t group_results_due[$];

  // Predicted group state.
  logic [2:0]         active_mode = sega_pkg::MODE_SINGLE;
  logic [63:0]        grp_src = '0;
  logic [63:0]        grp_tgt = '0;
  logic [63:0]        grp_kind = '0;
  logic [30:0]        grp_size = '0;
  logic [63:0]        grp_pick = '0;
  logic signed [63:0] grp_total = '0;
  logic signed [63:0] grp_low = '0;
  logic signed [63:0] grp_high = '0;
  bit                 grp_open = 1'b0;
  bit                 dropping_batch = 1'b0;

  bit          rec_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          steady = 1'b0;
  int          pushed_count = 0;
  int          accepted_count = 0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  logic [63:0] key_src = '0;
  logic [63:0] key_tgt = '0;
  logic [63:0] key_kind = '0;

  sorted_edge_group_aggregator_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .source_node(cur_rec.src),
    .target_node(cur_rec.tgt),
    .edge_kind(cur_rec.kind),
    .edge_ident(cur_rec.ident),
    .weight(cur_rec.weight),
    .batch_end(cur_rec.be),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pick_edge(pick_edge),
    .group_count(group_count),
    .aggregate(aggregate),
    .status(status),
    .last_of_batch(last_of_batch),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .mode(mode)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      r = a[63] ? sega_pkg::Q_MIN : sega_pkg::Q_MAX;
    end
    return r;
  endfunction

  function automatic sega_pkg::res_t closing_result(input bit last);
    sega_pkg::res_t g;
    g.pick_edge = grp_pick;
    g.group_count = grp_size;
    g.status = 1'b0;
    g.last_of_batch = last;
    case (active_mode)
      sega_pkg::MODE_COUNT: g.aggregate = {1'b0, grp_size, 32'd0};
      sega_pkg::MODE_SUM:   g.aggregate = grp_total;
      sega_pkg::MODE_MIN:   g.aggregate = grp_low;
      sega_pkg::MODE_MAX:   g.aggregate = grp_high;
      default:              g.aggregate = '0;
    endcase
    return g;
  endfunction

  task automatic reduce_record(input edge_rec_t r);
    sega_pkg::res_t g;
    if (dropping_batch) begin
      if (r.be) begin
        dropping_batch = 1'b0;
        grp_open = 1'b0;
      end
      return;
    end
    if (grp_open && r.src == grp_src && r.tgt == grp_tgt && r.kind == grp_kind) begin
      if (grp_size != sega_pkg::COUNT_MAX) begin
        grp_size++;
      end
      if (active_mode >= sega_pkg::MODE_SINGLE) begin
        g.pick_edge = grp_pick;
        g.group_count = grp_size;
        g.aggregate = '0;
        g.status = 1'b1;
        g.last_of_batch = r.be;
        group_results_due.push_back(g);
        grp_open = 1'b0;
        dropping_batch = !r.be;
        return;
      end
      grp_total = sat_sum(grp_total, r.weight);
      if (r.weight < grp_low) begin
        grp_low = r.weight;
        if (active_mode == sega_pkg::MODE_MIN) begin
          grp_pick = r.ident;
        end
      end
      if (r.weight > grp_high) begin
        grp_high = r.weight;
        if (active_mode == sega_pkg::MODE_MAX) begin
          grp_pick = r.ident;
        end
      end
    end else begin
      if (grp_open) begin
        group_results_due.push_back(closing_result(1'b0));
      end
      grp_src = r.src;
      grp_tgt = r.tgt;
      grp_kind = r.kind;
      grp_size = 31'd1;
      grp_pick = r.ident;
      grp_total = r.weight;
      grp_low = r.weight;
      grp_high = r.weight;
      grp_open = 1'b1;
    end
    if (r.be) begin
      group_results_due.push_back(closing_result(1'b1));
      grp_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    sega_pkg::res_t exp_res;
    rec_taken = !rst && in_valid && !in_stall;
    res_taken = !rst && out_valid && !out_stall;
    if (!rst && cfg_valid && cfg_ready) begin
      active_mode = mode;
    end
    if (rec_taken) begin
      reduce_record(cur_rec);
      accepted_count++;
    end
    if (res_taken) begin
      if (group_results_due.size() == 0) begin
        $error("unexpected result: pick_edge %h group_count %0d", pick_edge, group_count);
        error_count++;
      end else begin
        exp_res = group_results_due.pop_front();
        if (pick_edge !== exp_res.pick_edge) begin
          $error("pick_edge: expected %h, actual %h", exp_res.pick_edge, pick_edge);
          error_count++;
        end
        if (group_count !== exp_res.group_count) begin
          $error("group_count: expected %0d, actual %0d", exp_res.group_count, group_count);
          error_count++;
        end
        if (aggregate !== exp_res.aggregate) begin
          $error("aggregate: expected %h, actual %h", exp_res.aggregate, aggregate);
          error_count++;
        end
        if (status !== exp_res.status) begin
          $error("status: expected %b, actual %b", exp_res.status, status);
          error_count++;
        end
        if (last_of_batch !== exp_res.last_of_batch) begin
          $error("last_of_batch: expected %b, actual %b", exp_res.last_of_batch,
                 last_of_batch);
          error_count++;
        end
      end
    end
    if (rst || rec_taken || res_taken || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // A record that is offered stays on the bus until its transfer.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !rec_taken)) begin
      if (record_queue.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        cur_rec <= record_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && !steady && ($urandom_range(99) < 11);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [63:0] random_weight();
    logic signed [63:0] w;
    logic [31:0]        r;
    case ($urandom_range(7))
      0:       w = sega_pkg::Q_MAX - $urandom_range(3);
      1:       w = sega_pkg::Q_MIN + $urandom_range(3);
      2, 3:    w = rand64();
      4: begin
        w = $urandom_range(4);
        w = (w - 2) <<< 32;
      end
      default: begin
        r = $urandom();
        w = {{32{r[31]}}, r};
      end
    endcase
    return w;
  endfunction

  task automatic queue_record(input logic [63:0] src, input logic [63:0] tgt,
                              input logic [63:0] kind, input logic [63:0] ident,
                              input logic signed [63:0] weight, input logic be);
    edge_rec_t r;
    r.src = src;
    r.tgt = tgt;
    r.kind = kind;
    r.ident = ident;
    r.weight = weight;
    r.be = be;
    record_queue.push_back(r);
    pushed_count++;
  endtask

  // Mostly sorted runs of equal keys with random content, plus unsorted jumps.
  task automatic queue_random_phase();
    int run_len;
    int n;
    bit be;
    n = 0;
    while (n < 30) begin
      case ($urandom_range(9))
        0, 1: key_kind += 1;
        2, 3: begin
          key_tgt += $urandom_range(1, 3);
          key_kind = $urandom_range(3);
        end
        4, 5: begin
          key_src += 1;
          key_tgt = $urandom_range(3);
          key_kind = '0;
        end
        6, 7: begin
          key_src = rand64();
          key_tgt = rand64();
          key_kind = rand64();
        end
        8: begin
          key_src = '1;
          key_tgt = '1;
          key_kind = $urandom_range(1) ? '1 : '0;
        end
        default: begin
          key_src = '0;
          key_tgt = '0;
          key_kind = $urandom_range(1);
        end
      endcase
      run_len = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      for (int i = 0; i < run_len; i++) begin
        be = (i == run_len - 1) ? ($urandom_range(5) == 0) : ($urandom_range(19) == 0);
        queue_record(key_src, key_tgt, key_kind, rand64(), random_weight(), be);
      end
      n += run_len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != pushed_count || group_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic [2:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    mode <= m;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int random_base;
    int p;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset mode rejects parallel edges; the all-zero key must not match the closed group.
    queue_record('0, '0, '0, '1, sega_pkg::Q_MIN, 1'b0);
    queue_record('1, '1, '1, '0, sega_pkg::Q_MAX, 1'b0);
    queue_record('1, '1, '1, 64'h5, 0, 1'b0);
    queue_record(1, 2, 3, 64'h7, 0, 1'b0);
    queue_record(1, 2, 3, 64'h8, 0, 1'b1);
    queue_record(1, 2, 3, 64'h9, 64'sd1 <<< 32, 1'b1);
    wait_idle();

    // The group left open here is flushed after the mode has changed to SUM.
    write_mode(sega_pkg::MODE_COUNT);
    queue_record(10, 20, 30, 64'h100, sega_pkg::Q_MAX, 1'b0);
    queue_record(10, 20, 30, 64'h101, sega_pkg::Q_MAX, 1'b0);
    wait_idle();

    write_mode(sega_pkg::MODE_SUM);
    queue_record(10, 20, 30, 64'h102, 5, 1'b1);
    queue_record(11, 0, 0, 64'h200, sega_pkg::Q_MIN, 1'b0);
    queue_record(11, 0, 0, 64'h201, -1, 1'b0);
    queue_record(3, 3, 3, 64'h300, -2, 1'b0);
    wait_idle();

    write_mode(sega_pkg::MODE_MIN);
    queue_record(3, 3, 3, 64'h301, 3, 1'b0);
    queue_record(3, 3, 3, 64'h302, -7, 1'b0);
    queue_record(3, 3, 3, 64'h303, -7, 1'b0);
    queue_record(4, 0, 0, 64'h400, 0, 1'b1);
    wait_idle();

    write_mode(sega_pkg::MODE_MAX);
    queue_record(5, 5, 5, 64'h500, -1, 1'b0);
    queue_record(5, 5, 5, 64'h501, 10, 1'b0);
    queue_record(5, 5, 5, 64'h502, 10, 1'b0);
    queue_record(5, 5, 5, 64'h503, sega_pkg::Q_MAX, 1'b1);
    wait_idle();

    // Unused mode codes behave like SINGLE.
    write_mode(3'd7);
    queue_record(6, 6, 6, 64'h600, 0, 1'b0);
    queue_record(6, 6, 6, 64'h601, 0, 1'b1);
    queue_record(7, 7, 7, 64'h700, 0, 1'b0);
    wait_idle();

    write_mode(3'd5);
    queue_record(7, 7, 7, 64'h701, 0, 1'b0);
    queue_record(8, 8, 8, 64'h800, 0, 1'b1);
    wait_idle();

    random_base = pushed_count;
    p = 0;
    while (pushed_count - random_base < RANDOM_RECORDS) begin
      steady = (p >= 3 && p <= 5);
      write_mode((p < 8) ? p[2:0] : 3'($urandom_range(7)));
      queue_random_phase();
      wait_idle();
      p++;
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
